### rtl/core/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Shared types, register codes and helper functions for the UART register
// block: item and result records, FIFO storage control, pointer arithmetic.
// ----------------------------------------------------------------------------
package urb_pkg;

    // Entries in each of the receive and transmit FIFOs.
    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Receive entry: character in bits 7:0, parity, framing, break above it.
    localparam int RX_ENT_W   = 11;
    localparam int RX_FLAG_W  = 3;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_RX    = 2'd2,
        FUNC_TXREQ = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ADDR_DATA    = 3'd0,
        ADDR_IER     = 3'd1,
        ADDR_IIR_FCR = 3'd2,
        ADDR_LCR     = 3'd3,
        ADDR_MCR     = 3'd4,
        ADDR_LSR     = 3'd5,
        ADDR_MSR     = 3'd6,
        ADDR_SCR     = 3'd7
    } reg_addr_t;

    // Interrupt identification codes.
    localparam logic [7:0] IIR_NO_INT   = 8'h01;
    localparam logic [7:0] IIR_RLS      = 8'h06;
    localparam logic [7:0] IIR_RDA      = 8'h04;
    localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
    localparam logic [7:0] IIR_FIFO     = 8'hC0;

    // Line status bits.
    localparam logic [7:0] LSR_DR       = 8'h01;
    localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
    localparam logic [7:0] LSR_RX_ERR   = 8'h80;

    typedef struct packed {
        func_t                func;
        reg_addr_t            addr;
        logic [7:0]           wdata;
        logic [7:0]           rx_byte;
        logic                 rx_parity_err;
        logic                 rx_framing_err;
        logic                 rx_break;
    } item_t;

    typedef struct packed {
        logic [7:0]           rdata;
        logic                 irq;
        logic                 tx_valid;
        logic [7:0]           tx_byte;
    } result_t;

    // Write enables, addresses and data, and read-ahead addresses for the FIFO storage.
    typedef struct packed {
        logic                 rx_we;
        logic [PTR_W-1:0]     rx_waddr;
        logic [RX_ENT_W-1:0]  rx_wdata;
        logic [PTR_W-1:0]     rx_raddr;
        logic [PTR_W-1:0]     rx_raddr_nx;
        logic                 tx_we;
        logic [PTR_W-1:0]     tx_waddr;
        logic [7:0]           tx_wdata;
        logic [PTR_W-1:0]     tx_raddr;
    } store_ctl_t;

    typedef struct packed {
        logic [RX_ENT_W-1:0]  rx_head_ent;
        logic [RX_FLAG_W-1:0] rx_next_flags;
        logic [7:0]           tx_head_byte;
    } store_rd_t;

    // Pointer plus count, wrapped at the FIFO depth.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
        if (s >= (CNT_W+1)'(FIFO_DEPTH)) begin
            s = s - (CNT_W+1)'(FIFO_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return ptr_add(p, CNT_W'(1));
    endfunction

    // Receive trigger level: 1, 4, 8 or 14, capped at the depth; 1 when the FIFOs are disabled.
    function automatic logic [CNT_W-1:0] trig_level(input logic       en,
                                                    input logic [1:0] code);
        logic [7:0] t;
        unique case (code)
            2'd0: t = 8'd1;
            2'd1: t = 8'd4;
            2'd2: t = 8'd8;
            2'd3: t = 8'd14;
            default: t = 8'd1;
        endcase
        if (!en) begin
            t = 8'd1;
        end
        if (t > 8'(FIFO_DEPTH)) begin
            t = 8'(FIFO_DEPTH);
        end
        return t[CNT_W-1:0];
    endfunction

    // Highest priority pending interrupt cause.
    function automatic logic [7:0] iir_code(input logic [3:0]       ier,
                                            input logic [3:0]       lerr,
                                            input logic [CNT_W-1:0] rx_cnt,
                                            input logic [CNT_W-1:0] trig,
                                            input logic             thre);
        logic [7:0] c;
        priority if (ier[2] && lerr != 4'd0) begin
            c = IIR_RLS;
        end else if (ier[0] && rx_cnt >= trig) begin
            c = IIR_RDA;
        end else if (ier[1] && thre) begin
            c = IIR_TX_EMPTY;
        end else begin
            c = IIR_NO_INT;
        end
        return c;
    endfunction

endpackage

### rtl/core/uart_register_block.sv
// ----------------------------------------------------------------------------
// uart_register_block
// Register side of a 16550-style UART: bus reads and writes, received
// characters and transmit shifter requests enter as one request stream;
// each request yields one result with read data, interrupt and transmit byte.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | tdata (low bit first)                          | tuser
//  --------+-----+------------------------------------------------+-------
//  s_      | in  | addr[2:0] wdata[10:3] rx_byte[18:11]           | func
//          |     | parity[19] framing[20] break[21] zero[23:22]   |
//  m_      | out | rdata[7:0] irq[8] tx_valid[9] tx_byte[17:10]   | -
//          |     | zero[23:18]                                    |
//
// One request is accepted per clock while s_tready is high, and every request
// produces exactly one result. A request is captured in the input register,
// applied to the register file and FIFO pointers when it leaves that register,
// and its result is held in the output register.
// The FIFO storage is RAM with a registered read; the head entry is read
// ahead from the pointer that the request in flight leaves behind, and
// a write to that address is forwarded, so back-to-back pops and pushes run
// at full rate.
// Reset is synchronous and active low; there is no clearing pass, since FIFO
// entries are only read within the fill count.
// When m_tready is low the result holds, one further request may wait in the
// input register, and s_tready drops only when both are occupied.
//
module uart_register_block
    import urb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // addr[2:0], wdata[10:3], rx_byte[18:11], rx_parity_err[19],
    // rx_framing_err[20], rx_break[21], zero[23:22]
    input  logic [23:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // rdata[7:0], irq[8], tx_valid[9], tx_byte[17:10], zero[23:18]
    output logic [23:0] m_tdata
);

    item_t      item_reg;
    logic       item_valid_reg;
    result_t    result_reg;
    logic       m_valid_reg;

    logic       advance;
    result_t    result;
    store_ctl_t store_ctl;
    store_rd_t  store_rd;

    // The request in the input register moves on whenever the output
    // register is empty or is being emptied in this cycle.
    assign advance  = item_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg.func           <= func_t'(s_tuser);
            item_reg.addr           <= reg_addr_t'(s_tdata[2:0]);
            item_reg.wdata          <= s_tdata[10:3];
            item_reg.rx_byte        <= s_tdata[18:11];
            item_reg.rx_parity_err  <= s_tdata[19];
            item_reg.rx_framing_err <= s_tdata[20];
            item_reg.rx_break       <= s_tdata[21];
        end
    end

    urb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .rd      (store_rd),
        .ctl     (store_ctl),
        .result  (result)
    );

    urb_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (store_ctl),
        .rd      (store_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, result_reg.tx_byte, result_reg.tx_valid,
                       result_reg.irq, result_reg.rdata};

    // Read data is only ever returned for bus reads.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.func != FUNC_READ) |=> (m_tdata[7:0] == 8'h00))
        else $error("read data returned for a request that is not a read");

    // Only a shifter request can hand a byte to the transmitter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.func != FUNC_TXREQ) |=> !m_tdata[9])
        else $error("transmit byte issued for a request that is not a shifter request");

    // With a result stalled and a request waiting, nothing more may enter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && item_valid_reg) |-> !s_tready)
        else $error("request accepted while both stages are occupied");

endmodule

### rtl/core/urb_ram.sv
// ----------------------------------------------------------------------------
// urb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/urb_store.sv
// ----------------------------------------------------------------------------
// urb_store
// FIFO storage: receive entries, receive flags read one ahead, transmit bytes.
// Reads are issued ahead; a write to the address being read is
// forwarded so the head data is current.
// ----------------------------------------------------------------------------
module urb_store
    import urb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  store_ctl_t ctl,
    output store_rd_t  rd
);

    logic [RX_ENT_W-1:0]  rx_ram_q;
    logic [RX_FLAG_W-1:0] rx_nx_ram_q;
    logic [7:0]           tx_ram_q;

    logic                 fwd_rx_reg;
    logic                 fwd_rx_nx_reg;
    logic                 fwd_tx_reg;
    logic [RX_ENT_W-1:0]  rx_wdata_reg;
    logic [7:0]           tx_wdata_reg;

    urb_ram #(.WIDTH(RX_ENT_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
        .aclk  (aclk),
        .we    (ctl.rx_we),
        .waddr (ctl.rx_waddr),
        .wdata (ctl.rx_wdata),
        .raddr (ctl.rx_raddr),
        .rdata (rx_ram_q)
    );

    // Flag copy of the receive store, read at the entry behind the head.
    urb_ram #(.WIDTH(RX_FLAG_W), .DEPTH(FIFO_DEPTH)) u_rx_flag_ram (
        .aclk  (aclk),
        .we    (ctl.rx_we),
        .waddr (ctl.rx_waddr),
        .wdata (ctl.rx_wdata[RX_ENT_W-1:8]),
        .raddr (ctl.rx_raddr_nx),
        .rdata (rx_nx_ram_q)
    );

    urb_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
        .aclk  (aclk),
        .we    (ctl.tx_we),
        .waddr (ctl.tx_waddr),
        .wdata (ctl.tx_wdata),
        .raddr (ctl.tx_raddr),
        .rdata (tx_ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_rx_reg    <= 1'b0;
            fwd_rx_nx_reg <= 1'b0;
            fwd_tx_reg    <= 1'b0;
        end else begin
            fwd_rx_reg    <= ctl.rx_we && (ctl.rx_waddr == ctl.rx_raddr);
            fwd_rx_nx_reg <= ctl.rx_we && (ctl.rx_waddr == ctl.rx_raddr_nx);
            fwd_tx_reg    <= ctl.tx_we && (ctl.tx_waddr == ctl.tx_raddr);
        end
        rx_wdata_reg <= ctl.rx_wdata;
        tx_wdata_reg <= ctl.tx_wdata;
    end

    assign rd.rx_head_ent   = fwd_rx_reg ? rx_wdata_reg : rx_ram_q;
    assign rd.rx_next_flags = fwd_rx_nx_reg ? rx_wdata_reg[RX_ENT_W-1:8] : rx_nx_ram_q;
    assign rd.tx_head_byte  = fwd_tx_reg ? tx_wdata_reg : tx_ram_q;

endmodule

### rtl/core/urb_regs.sv
// ----------------------------------------------------------------------------
// urb_regs
// Register file and FIFO pointers of the UART: applies one bus access or
// line event per cycle while advance is high, and forms the result record.
// ----------------------------------------------------------------------------
module urb_regs
    import urb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  item_t      item,
    input  store_rd_t  rd,
    output store_ctl_t ctl,
    output result_t    result
);

    logic [PTR_W-1:0] rx_head_reg,   rx_head_next;
    logic [CNT_W-1:0] rx_count_reg,  rx_count_next;
    logic [CNT_W-1:0] rx_errcnt_reg, rx_errcnt_next;
    logic [PTR_W-1:0] tx_head_reg,   tx_head_next;
    logic [CNT_W-1:0] tx_count_reg,  tx_count_next;
    logic [3:0]       ier_reg,       ier_next;
    logic [7:0]       lcr_reg,       lcr_next;
    logic [4:0]       mcr_reg,       mcr_next;
    logic [7:0]       dll_reg,       dll_next;
    logic [7:0]       dlh_reg,       dlh_next;
    logic             fifo_en_reg,   fifo_en_next;
    logic [1:0]       trig_reg,      trig_next;
    logic [3:0]       lerr_reg,      lerr_next;
    logic             thre_reg,      thre_next;

    logic                 dlab;
    logic [CNT_W-1:0]     depth_now;
    logic [RX_FLAG_W-1:0] head_flags;
    logic [RX_FLAG_W-1:0] in_flags;
    logic [7:0]           iir_now;
    logic                 fcr_on;
    logic                 clr_rx;
    logic                 clr_tx;

    always_comb begin
        rx_head_next   = rx_head_reg;
        rx_count_next  = rx_count_reg;
        rx_errcnt_next = rx_errcnt_reg;
        tx_head_next   = tx_head_reg;
        tx_count_next  = tx_count_reg;
        ier_next       = ier_reg;
        lcr_next       = lcr_reg;
        mcr_next       = mcr_reg;
        dll_next       = dll_reg;
        dlh_next       = dlh_reg;
        fifo_en_next   = fifo_en_reg;
        trig_next      = trig_reg;
        lerr_next      = lerr_reg;
        thre_next      = thre_reg;
        result         = '0;
        ctl            = '0;
        fcr_on         = 1'b0;
        clr_rx         = 1'b0;
        clr_tx         = 1'b0;

        dlab       = lcr_reg[7];
        depth_now  = fifo_en_reg ? CNT_W'(FIFO_DEPTH) : CNT_W'(1);
        head_flags = rd.rx_head_ent[RX_ENT_W-1:8];
        in_flags   = {item.rx_break, item.rx_framing_err, item.rx_parity_err};
        iir_now    = iir_code(ier_reg, lerr_reg, rx_count_reg,
                              trig_level(fifo_en_reg, trig_reg), thre_reg);

        ctl.rx_wdata = {in_flags, item.rx_byte};
        ctl.tx_wdata = item.wdata;

        if (advance) begin
            unique case (item.func)
                FUNC_READ: begin
                    unique case (item.addr)
                        ADDR_DATA: begin
                            if (dlab) begin
                                result.rdata = dll_reg;
                            end else if (rx_count_reg != '0) begin
                                result.rdata   = rd.rx_head_ent[7:0];
                                rx_head_next   = ptr_inc(rx_head_reg);
                                rx_count_next  = rx_count_reg - CNT_W'(1);
                                rx_errcnt_next = rx_errcnt_reg -
                                                 CNT_W'(head_flags != '0);
                                // The next entry's flags show once it is at the head.
                                if (rx_count_reg > CNT_W'(1)) begin
                                    lerr_next = lerr_reg | {rd.rx_next_flags, 1'b0};
                                end
                            end
                        end
                        ADDR_IER: begin
                            result.rdata = dlab ? dlh_reg : {4'd0, ier_reg};
                        end
                        ADDR_IIR_FCR: begin
                            if (iir_now == IIR_TX_EMPTY) begin
                                thre_next = 1'b0;
                            end
                            result.rdata = iir_now | (fifo_en_reg ? IIR_FIFO : 8'h00);
                        end
                        ADDR_LCR: begin
                            result.rdata = lcr_reg;
                        end
                        ADDR_MCR: begin
                            result.rdata = {3'd0, mcr_reg};
                        end
                        ADDR_LSR: begin
                            result.rdata = {3'd0, lerr_reg, 1'b0};
                            if (rx_count_reg != '0) begin
                                result.rdata = result.rdata | LSR_DR;
                            end
                            if (tx_count_reg == '0) begin
                                result.rdata = result.rdata | LSR_TX_EMPTY;
                            end
                            if (fifo_en_reg && rx_errcnt_reg != '0) begin
                                result.rdata = result.rdata | LSR_RX_ERR;
                            end
                            lerr_next = 4'd0;
                        end
                        ADDR_MSR, ADDR_SCR: begin
                            result.rdata = 8'h00;
                        end
                        default: begin
                            result.rdata = 8'h00;
                        end
                    endcase
                end
                FUNC_WRITE: begin
                    unique case (item.addr)
                        ADDR_DATA: begin
                            if (dlab) begin
                                dll_next = item.wdata;
                            end else begin
                                if (tx_count_reg < depth_now) begin
                                    ctl.tx_we     = 1'b1;
                                    ctl.tx_waddr  = ptr_add(tx_head_reg, tx_count_reg);
                                    tx_count_next = tx_count_reg + CNT_W'(1);
                                end
                                thre_next = 1'b0;
                            end
                        end
                        ADDR_IER: begin
                            if (dlab) begin
                                dlh_next = item.wdata;
                            end else begin
                                if (item.wdata[1] && !ier_reg[1] && tx_count_reg == '0) begin
                                    thre_next = 1'b1;
                                end
                                ier_next = item.wdata[3:0];
                            end
                        end
                        ADDR_IIR_FCR: begin
                            fcr_on = item.wdata[0];
                            if (fcr_on != fifo_en_reg) begin
                                clr_rx = 1'b1;
                                clr_tx = 1'b1;
                            end
                            if (fcr_on) begin
                                clr_rx       = clr_rx | item.wdata[1];
                                clr_tx       = clr_tx | item.wdata[2];
                                fifo_en_next = 1'b1;
                                trig_next    = item.wdata[7:6];
                            end else begin
                                fifo_en_next = 1'b0;
                            end
                            if (clr_rx) begin
                                rx_head_next   = '0;
                                rx_count_next  = '0;
                                rx_errcnt_next = '0;
                            end
                            if (clr_tx) begin
                                tx_head_next  = '0;
                                tx_count_next = '0;
                                thre_next     = 1'b1;
                            end
                        end
                        ADDR_LCR: begin
                            lcr_next = item.wdata;
                        end
                        ADDR_MCR: begin
                            mcr_next = item.wdata[4:0];
                        end
                        ADDR_LSR, ADDR_MSR, ADDR_SCR: begin
                        end
                        default: begin
                        end
                    endcase
                end
                FUNC_RX: begin
                    if (rx_count_reg >= depth_now) begin
                        lerr_next = lerr_reg | 4'b0001;
                    end else begin
                        ctl.rx_we      = 1'b1;
                        ctl.rx_waddr   = ptr_add(rx_head_reg, rx_count_reg);
                        rx_count_next  = rx_count_reg + CNT_W'(1);
                        rx_errcnt_next = rx_errcnt_reg + CNT_W'(in_flags != '0);
                        if (rx_count_reg == '0) begin
                            lerr_next = lerr_reg | {in_flags, 1'b0};
                        end
                    end
                end
                FUNC_TXREQ: begin
                    if (tx_count_reg != '0) begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = rd.tx_head_byte;
                        tx_head_next    = ptr_inc(tx_head_reg);
                        tx_count_next   = tx_count_reg - CNT_W'(1);
                        if (tx_count_reg == CNT_W'(1)) begin
                            thre_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        result.irq = iir_code(ier_next, lerr_next, rx_count_next,
                              trig_level(fifo_en_next, trig_next),
                              thre_next) != IIR_NO_INT;

        // Read ahead at the head the next item will see.
        if (!aresetn) begin
            ctl.rx_raddr    = '0;
            ctl.rx_raddr_nx = '0;
            ctl.tx_raddr    = '0;
        end else begin
            ctl.rx_raddr    = rx_head_next;
            ctl.rx_raddr_nx = ptr_inc(rx_head_next);
            ctl.tx_raddr    = tx_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_head_reg   <= '0;
            rx_count_reg  <= '0;
            rx_errcnt_reg <= '0;
            tx_head_reg   <= '0;
            tx_count_reg  <= '0;
            ier_reg       <= '0;
            lcr_reg       <= '0;
            mcr_reg       <= '0;
            dll_reg       <= '0;
            dlh_reg       <= '0;
            fifo_en_reg   <= 1'b0;
            trig_reg      <= '0;
            lerr_reg      <= '0;
            thre_reg      <= 1'b1;
        end else begin
            rx_head_reg   <= rx_head_next;
            rx_count_reg  <= rx_count_next;
            rx_errcnt_reg <= rx_errcnt_next;
            tx_head_reg   <= tx_head_next;
            tx_count_reg  <= tx_count_next;
            ier_reg       <= ier_next;
            lcr_reg       <= lcr_next;
            mcr_reg       <= mcr_next;
            dll_reg       <= dll_next;
            dlh_reg       <= dlh_next;
            fifo_en_reg   <= fifo_en_next;
            trig_reg      <= trig_next;
            lerr_reg      <= lerr_next;
            thre_reg      <= thre_next;
        end
    end

endmodule
